>>> sv/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, codes and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned NODE_BYTES     = 8;
  localparam int unsigned CAP_MAX        = 4096;
  localparam int unsigned ALIGN_MAX      = 12;
  localparam int unsigned OFF_W          = 24;
  localparam int unsigned STRIDE_W       = 13;
  localparam int unsigned DIV_CNT_W      = $clog2(OFF_W);

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_BAD_ALIGN  = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_RANGE      = 3'd4;
  localparam logic [2:0] ST_MISALIGN   = 3'd5;
  localparam logic [2:0] ST_DOUBLE     = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 2'd2;

  localparam logic [12:0] CAPACITY_RST = 13'd64;
  localparam logic [3:0]  ALIGN_RST    = 4'd3;
  localparam logic [10:0] COUNT_RST    = 11'd1024;

  typedef struct packed {
    logic capture;
    logic stride;
    logic total;
    logic fill;
    logic clr_peak;
    logic clr_step;
    logic eval;
    logic pop;
    logic alloc_commit;
    logic alloc_mul;
    logic div_step;
    logic set_misalign;
    logic bm_rd;
    logic free_commit;
    logic res_load;
  } fbpa_cmd_t;

  typedef struct packed {
    logic       cfg_hit;
    logic [1:0] op;
    logic [2:0] pre_err;
    logic       div_done;
    logic       rem_zero;
    logic       clr_done;
    logic       out_busy;
  } fbpa_stat_t;

endpackage

>>> sv/fbpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Command sequencer: steps each command through the datapath.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  fbpa_pkg::fbpa_stat_t stat,
  output fbpa_pkg::fbpa_cmd_t  cmd
);
  import fbpa_pkg::*;

  typedef enum logic [3:0] {
    S_CFG, S_TOTAL, S_CLR_CFG, S_IDLE, S_EVAL, S_POP, S_AIDX, S_AMUL,
    S_DIV, S_DCHK, S_FCHK, S_CLR_OP, S_FIN
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CFG: begin
        cmd.stride = 1'b1;
        state_next = S_TOTAL;
      end
      S_TOTAL: begin
        cmd.total    = 1'b1;
        cmd.fill     = 1'b1;
        cmd.clr_peak = 1'b1;
        state_next   = S_CLR_CFG;
      end
      S_CLR_CFG: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        unique case (stat.op)
          OP_ALLOC: state_next = (stat.pre_err == ST_OK) ? S_POP : S_FIN;
          OP_FREE:  state_next = (stat.pre_err == ST_OK) ? S_DIV : S_FIN;
          OP_RESET: begin
            cmd.fill   = 1'b1;
            state_next = S_CLR_OP;
          end
          default:  state_next = S_FIN;
        endcase
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_AIDX;
      end
      S_AIDX: begin
        cmd.alloc_commit = 1'b1;
        state_next       = S_AMUL;
      end
      S_AMUL: begin
        cmd.alloc_mul = 1'b1;
        state_next    = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_DCHK;
      end
      S_DCHK: begin
        if (stat.rem_zero) begin
          cmd.bm_rd  = 1'b1;
          state_next = S_FCHK;
        end else begin
          cmd.set_misalign = 1'b1;
          state_next       = S_FIN;
        end
      end
      S_FCHK: begin
        cmd.free_commit = 1'b1;
        state_next      = S_FIN;
      end
      S_CLR_OP: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CFG;
    endcase
    // a register write rebuilds the pool from scratch
    if (stat.cfg_hit) begin
      cmd        = '0;
      state_next = S_CFG;
    end
  end

  // hold off commands in the cycle a register write lands
  assign s_tready = (state == S_IDLE) && !stat.cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CFG;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/fbpa_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_dpath
// Registers, free stack, in-use bitmap, divider and result register.
// ----------------------------------------------------------------------------
module fbpa_dpath #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [fbpa_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [fbpa_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  fbpa_pkg::fbpa_cmd_t               cmd,
  output fbpa_pkg::fbpa_stat_t              stat
);
  import fbpa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned TW = STRIDE_W + CW;

  // configuration
  logic [12:0] block_capacity;
  logic [3:0]  pool_align_log2;
  logic [10:0] block_count;

  // pool state
  logic [STRIDE_W-1:0] stride;
  logic [CW-1:0]       eff_cnt;
  logic [TW-1:0]       total;
  logic [CW-1:0]       depth;
  logic [CW-1:0]       low_mark;
  logic [CW-1:0]       used;
  logic [CW-1:0]       peak;
  logic [IW-1:0]       clr_addr;

  // captured command
  logic [1:0]       op;
  logic [15:0]      req_size;
  logic [3:0]       req_align;
  logic [OFF_W-1:0] offset;

  // divider
  logic [STRIDE_W-1:0]  rem;
  logic [OFF_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] div_cnt;

  // alloc
  logic [IW-1:0] pos;
  logic          pos_ident;
  logic [IW-1:0] alloc_idx;

  // memories
  logic [IW-1:0] stk_mem [MAX_BLOCKS];
  logic          bm_mem  [MAX_BLOCKS];
  logic [IW-1:0] stk_rdata;
  logic          bm_rdata;

  // result
  logic [2:0]  res_status;
  logic [9:0]  res_idx;
  logic [21:0] res_off;
  logic [2:0]  o_status;
  logic [9:0]  o_idx;
  logic [21:0] o_off;
  logic [10:0] o_used;
  logic [10:0] o_peak;

  logic [12:0]         cap_c;
  logic [3:0]          align_c;
  logic [12:0]         amask;
  logic [12:0]         cap_n;
  logic [STRIDE_W-1:0] stride_new;
  logic [CW-1:0]       eff_new;
  logic [2:0]          pre_err;
  logic [STRIDE_W:0]   div_trial;
  logic                div_ge;
  logic [CW-1:0]       used_inc;
  logic [IW-1:0]       quo_idx;

  always_comb begin
    if (block_capacity == 13'd0)                 cap_c = 13'd1;
    else if (32'(block_capacity) > CAP_MAX)      cap_c = 13'(CAP_MAX);
    else                                         cap_c = block_capacity;
    align_c = (32'(pool_align_log2) > ALIGN_MAX) ? 4'(ALIGN_MAX) : pool_align_log2;
    amask   = 13'((32'd1 << align_c) - 32'd1);
    cap_n   = (32'(cap_c) < NODE_BYTES) ? 13'(NODE_BYTES) : cap_c;
    stride_new = (cap_n + amask) & ~amask;
    eff_new = (32'(block_count) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(block_count);
  end

  always_comb begin
    pre_err = ST_OK;
    if (op == OP_ALLOC) begin
      if (req_size == 16'd0 || req_size > 16'(cap_c)) pre_err = ST_BAD_SIZE;
      else if (req_align > align_c)                   pre_err = ST_BAD_ALIGN;
      else if (depth == '0)                           pre_err = ST_EMPTY;
    end else if (op == OP_FREE) begin
      if (32'(offset) >= 32'(total)) pre_err = ST_RANGE;
    end
  end

  assign div_trial = {rem, quo[OFF_W-1]};
  assign div_ge    = div_trial >= {1'b0, stride};
  assign used_inc  = used + CW'(1);
  assign alloc_idx = pos_ident ? pos : stk_rdata;
  assign quo_idx   = quo[IW-1:0];

  assign stat.cfg_hit  = cfg_valid && (cfg_index == CFG_CAPACITY ||
                         cfg_index == CFG_ALIGN || cfg_index == CFG_COUNT);
  assign stat.op       = op;
  assign stat.pre_err  = pre_err;
  assign stat.div_done = (div_cnt == DIV_CNT_W'(OFF_W - 1));
  assign stat.rem_zero = (rem == '0);
  assign stat.clr_done = (clr_addr == IW'(MAX_BLOCKS - 1));
  assign stat.out_busy = m_tvalid && !m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_capacity  <= CAPACITY_RST;
      pool_align_log2 <= ALIGN_RST;
      block_count     <= COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CAPACITY: block_capacity  <= cfg_data;
        CFG_ALIGN:    pool_align_log2 <= cfg_data[3:0];
        CFG_COUNT:    block_count     <= cfg_data[10:0];
        default:      ;
      endcase
    end
  end

  // pool counters
  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= '0;
      low_mark <= '0;
      used     <= '0;
      peak     <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_peak) peak <= '0;
      if (cmd.fill) begin
        depth    <= eff_cnt;
        low_mark <= eff_cnt;
        used     <= '0;
        clr_addr <= '0;
      end
      if (cmd.clr_step) clr_addr <= clr_addr + IW'(1);
      if (cmd.pop) begin
        depth <= depth - CW'(1);
        if (depth - CW'(1) < low_mark) low_mark <= depth - CW'(1);
      end
      if (cmd.alloc_commit) begin
        used <= used_inc;
        if (used_inc > peak) peak <= used_inc;
      end
      if (cmd.free_commit && bm_rdata) begin
        if (32'(depth) < MAX_BLOCKS) depth <= depth + CW'(1);
        if (used != '0) used <= used - CW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.stride) begin
      stride  <= stride_new;
      eff_cnt <= eff_new;
    end
    if (cmd.total) total <= TW'(stride) * TW'(eff_cnt);
    if (cmd.capture) begin
      op        <= s_tdata[1:0];
      req_size  <= s_tdata[17:2];
      req_align <= s_tdata[21:18];
      offset    <= s_tdata[45:22];
    end
    if (cmd.eval) begin
      res_status <= pre_err;
      res_idx    <= '0;
      res_off    <= '0;
      rem        <= '0;
      quo        <= offset;
      div_cnt    <= '0;
    end
    if (cmd.div_step) begin
      rem     <= div_ge ? STRIDE_W'(div_trial - {1'b0, stride}) : div_trial[STRIDE_W-1:0];
      quo     <= {quo[OFF_W-2:0], div_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.pop) begin
      pos       <= IW'(depth - CW'(1));
      pos_ident <= (depth - CW'(1)) < low_mark;
    end
    if (cmd.alloc_commit) begin
      res_idx <= 10'(alloc_idx);
      pos     <= alloc_idx;
    end
    if (cmd.alloc_mul) res_off <= 22'((TW'(pos) * TW'(stride)));
    if (cmd.set_misalign) res_status <= ST_MISALIGN;
    if (cmd.free_commit) begin
      if (bm_rdata) begin
        res_idx <= 10'(quo_idx);
        res_off <= offset[21:0];
      end else begin
        res_status <= ST_DOUBLE;
      end
    end
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (cmd.free_commit && bm_rdata && 32'(depth) < MAX_BLOCKS)
      stk_mem[depth[IW-1:0]] <= quo_idx;
    if (cmd.pop) stk_rdata <= stk_mem[IW'(depth - CW'(1))];
  end

  // in-use bitmap memory
  always_ff @(posedge clk) begin
    if (cmd.clr_step)                     bm_mem[clr_addr]  <= 1'b0;
    else if (cmd.alloc_commit)            bm_mem[alloc_idx] <= 1'b1;
    else if (cmd.free_commit && bm_rdata) bm_mem[quo_idx]   <= 1'b0;
    if (cmd.bm_rd) bm_rdata <= bm_mem[quo_idx];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      o_status <= res_status;
      o_idx    <= res_idx;
      o_off    <= res_off;
      o_used   <= 11'(used);
      o_peak   <= 11'(peak);
    end
  end

  assign m_tdata = {7'd0, o_peak, o_used, o_off, o_idx, o_status};

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !(m_tvalid && !m_tready))
    else $error("result loaded over a beat not yet taken");
  a_used_peak: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> used <= peak)
    else $error("used count above peak");
  a_depth: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> 32'(depth) <= MAX_BLOCKS)
    else $error("free stack depth overflow");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> depth != '0 ##1 cmd.alloc_commit)
    else $error("pop from empty stack or broken alloc sequence");

endmodule

>>> sv/fixed_block_pool_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Fixed-size block pool manager with a LIFO free stack.
// ----------------------------------------------------------------------------
// One command a beat on the s_ side (alloc, free, reset of the free list), one
// result beat on the m_ side. Commands run one at a time: an alloc that passes
// its checks steps through check, stack read, bitmap update, index-times-stride
// multiply and result load; a free that passes the range check runs the
// 24-step restoring divider that turns the byte offset into a block index, and
// skips the bitmap check when the offset turns out misaligned; a command
// rejected at the first check, or the unused opcode, goes straight to the
// result load; a free-list reset runs the sweep that clears the in-use bitmap
// one entry a cycle. After reset and after every register write the pool is
// rebuilt: the stride and pool size are formed, then a bitmap clearing pass
// runs during which no command is taken. A result waiting on m_ does not stop
// the next command from being accepted and worked on; that command then holds
// until the result is taken.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // register write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
  // command stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // opcode[1:0], req_size[17:2], req_align_log2[21:18], free_offset[45:22]
  input  logic [fbpa_pkg::IN_DATA_W-1:0]  s_tdata,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[2:0], block_index[12:3], block_offset[34:13],
  // used_blocks[45:35], peak_blocks[56:46]
  output logic [fbpa_pkg::OUT_DATA_W-1:0] m_tdata
);
  import fbpa_pkg::*;

  fbpa_cmd_t  cmd;
  fbpa_stat_t stat;

  // registers are always writable; a write restarts the rebuild
  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbpa_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
